FILE: rtl/ccl_pkg.sv
// package for the cursor character list
// command codes, cell operations and status codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ccl_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam int IDX_W = 6;

	localparam logic [4:0] CMD_INS_AFTER = 5'd0;
	localparam logic [4:0] CMD_INS_FIRST = 5'd1;
	localparam logic [4:0] CMD_FIRST     = 5'd2;
	localparam logic [4:0] CMD_LAST      = 5'd3;
	localparam logic [4:0] CMD_NEXT      = 5'd4;
	localparam logic [4:0] CMD_PREV      = 5'd5;
	localparam logic [4:0] CMD_SEEK      = 5'd6;
	localparam logic [4:0] CMD_REPL_POS  = 5'd7;
	localparam logic [4:0] CMD_DELETE    = 5'd8;
	localparam logic [4:0] CMD_REPL_CUR  = 5'd9;
	localparam logic [4:0] CMD_FIND      = 5'd10;
	localparam logic [4:0] CMD_COUNT     = 5'd11;
	localparam logic [4:0] CMD_LIST      = 5'd12;
	localparam logic [4:0] CMD_UPPER     = 5'd13;
	localparam logic [4:0] CMD_LOWER     = 5'd14;
	localparam logic [4:0] CMD_TOGGLE    = 5'd15;
	localparam logic [4:0] CMD_CLEAR     = 5'd16;
	localparam logic [4:0] CMD_DUMP      = 5'd17;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NONE  = 2'd3;

	localparam logic [7:0] LOWER_A = 8'd97;
	localparam logic [7:0] LOWER_Z = 8'd122;
	localparam logic [7:0] UPPER_A = 8'd65;
	localparam logic [7:0] UPPER_Z = 8'd90;
	localparam logic [7:0] CASE_OFS = 8'd32;

	typedef enum logic [2:0] {
		OP_KEEP, OP_INS, OP_DEL, OP_SET, OP_UPPER, OP_LOWER, OP_TOGGLE, OP_ROT
	} cell_op_code_t;

	typedef struct packed {
		cell_op_code_t code;
		logic [IDX_W-1:0] idx;
		logic [7:0] val;
	} cell_op_t;
endpackage
`default_nettype wire

FILE: rtl/ccl_cell.sv
// one storage cell of the character chain
// depends on ccl_pkg for the cell operation struct
`timescale 1ns / 1ps
`default_nettype none
module ccl_cell import ccl_pkg::*; #(
	parameter int IDX = 0
) (
	input  wire logic     clk,
	input  wire cell_op_t op,
	input  wire logic [7:0] left,
	input  wire logic [7:0] right,
	output logic [7:0]    data
);
	logic [7:0] data_q;
	logic [7:0] nxt;
	logic is_lower, is_upper;
	logic at, above;

	assign at = op.idx == IDX_W'(IDX);
	assign above = IDX_W'(IDX) > op.idx;
	assign is_lower = data_q >= LOWER_A && data_q <= LOWER_Z;
	assign is_upper = data_q >= UPPER_A && data_q <= UPPER_Z;

	always_comb begin
		nxt = data_q;
		unique case (op.code)
			OP_KEEP: nxt = data_q;
			OP_INS: begin
				if (at) nxt = op.val;
				else if (above) nxt = left;
			end
			OP_DEL: if (at || above) nxt = right;
			OP_SET: if (at) nxt = op.val;
			OP_UPPER: if (is_lower) nxt = data_q - CASE_OFS;
			OP_LOWER: if (is_upper) nxt = data_q + CASE_OFS;
			OP_TOGGLE: begin
				if (is_lower) nxt = data_q - CASE_OFS;
				else if (is_upper) nxt = data_q + CASE_OFS;
			end
			OP_ROT: nxt = right;
			default: nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	assign data = data_q;
endmodule
`default_nettype wire

FILE: rtl/cursor_char_list_unit.sv
// cursor character list: a chain of byte cells with a command sequencer
// depends on ccl_pkg and ccl_cell
// steps: an edit state, a scan pass that rotates the chain through every cell, a
// finish state and a result state (skipped by a list with matches and by a dump of
// a non-empty list); list match results come in a second scan pass, dump results
// during the first pass; one request at a time, the next start is taken only when
// busy is low; results are not held
// reset clears length and cursor; cell contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none
module cursor_char_list_unit import ccl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [4:0] command,
	input  wire logic [7:0] value,
	input  wire logic [4:0] position,
	output logic            busy,
	output logic            done,
	output logic [1:0]      status,
	output logic [7:0]      item_value,
	output logic [4:0]      item_position,
	output logic [5:0]      match_count,
	output logic [5:0]      length,
	output logic            cursor_ok,
	output logic [4:0]      cursor_pos,
	output logic            last
);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = 8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EDIT  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FIN   = 3'd3;
	localparam logic [2:0] S_SCAN2 = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [4:0] cmd_q;
	logic [7:0] val_q;
	logic [4:0] pos_q;
	logic [LW-1:0] len_q;
	logic [IW-1:0] cur_q;
	logic cv_q;
	logic [1:0] st_q;
	logic [IW-1:0] scan_q;
	logic [LW-1:0] mc_q;
	logic [LW-1:0] run_q;
	logic found_q;
	logic [IW-1:0] first_q;
	logic [7:0] cb_q;
	logic [7:0] fb_q;

	logic [7:0] cell_data [CAPACITY];
	cell_op_t op;

	logic [7:0] head;
	logic in_range, counting, hit, scan_end;
	logic [IW-1:0] ins_p;
	logic [CW-1:0] pos_w, len_w, cur_w;

	assign head = cell_data[0];
	assign in_range = LW'(scan_q) < len_q;
	assign counting = cmd_q == CMD_FIND || cmd_q == CMD_COUNT || cmd_q == CMD_LIST;
	assign hit = in_range && counting && head == val_q;
	assign scan_end = scan_q == IW'(CAPACITY - 1);
	assign ins_p = (cmd_q == CMD_INS_AFTER && cv_q) ? cur_q + 1'b1 : '0;
	assign pos_w = CW'(pos_q);
	assign len_w = CW'(len_q);
	assign cur_w = CW'(cur_q);

	always_comb begin
		op.code = OP_KEEP;
		op.idx = '0;
		op.val = val_q;
		if (state_q == S_SCAN || state_q == S_SCAN2) begin
			op.code = OP_ROT;
		end else if (state_q == S_EDIT) begin
			unique case (cmd_q)
				CMD_INS_AFTER, CMD_INS_FIRST: begin
					if (len_q != LW'(CAPACITY)) begin
						op.code = OP_INS;
						op.idx = IDX_W'(ins_p);
					end
				end
				CMD_REPL_POS: begin
					if (pos_w < len_w) begin
						op.code = OP_SET;
						op.idx = IDX_W'(pos_q);
					end
				end
				CMD_DELETE: begin
					if (cv_q && cur_w < len_w) begin
						op.code = OP_DEL;
						op.idx = IDX_W'(cur_q);
					end
				end
				CMD_REPL_CUR: begin
					if (cv_q && cur_w < len_w) begin
						op.code = OP_SET;
						op.idx = IDX_W'(cur_q);
					end
				end
				CMD_UPPER: op.code = OP_UPPER;
				CMD_LOWER: op.code = OP_LOWER;
				CMD_TOGGLE: op.code = OP_TOGGLE;
				default: op.code = OP_KEEP;
			endcase
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [7:0] lft, rgt;
		if (k == 0) begin : g_l0
			assign lft = 8'h00;
		end else begin : g_l
			assign lft = cell_data[k-1];
		end
		if (k == CAPACITY - 1) begin : g_rl
			assign rgt = cell_data[0];
		end else begin : g_r
			assign rgt = cell_data[k+1];
		end
		ccl_cell #(.IDX(k)) u_cell (
			.clk(clk), .op(op), .left(lft), .right(rgt), .data(cell_data[k])
		);
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= command;
			val_q <= value;
			pos_q <= position;
		end
		if (state_q == S_EDIT) begin
			mc_q <= '0;
			run_q <= '0;
			found_q <= 1'b0;
			first_q <= '0;
			cb_q <= 8'h00;
			fb_q <= 8'h00;
		end
		if (state_q == S_SCAN) begin
			if (scan_q == cur_q) cb_q <= head;
			if (hit) begin
				mc_q <= mc_q + 1'b1;
				if (!found_q) begin
					found_q <= 1'b1;
					first_q <= scan_q;
					fb_q <= head;
				end
			end
		end
		if (state_q == S_SCAN2 && hit) run_q <= run_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			cur_q <= '0;
			cv_q <= 1'b0;
			st_q <= ST_OK;
			scan_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EDIT;
				S_EDIT: begin
					st_q <= ST_OK;
					scan_q <= '0;
					state_q <= S_SCAN;
					unique case (cmd_q)
						CMD_INS_AFTER, CMD_INS_FIRST: begin
							if (len_q == LW'(CAPACITY)) st_q <= ST_FULL;
							else begin
								len_q <= len_q + 1'b1;
								cur_q <= ins_p;
								cv_q <= 1'b1;
							end
						end
						CMD_FIRST: if (!cv_q) st_q <= ST_RANGE; else cur_q <= '0;
						CMD_LAST: begin
							if (!cv_q) st_q <= ST_RANGE;
							else cur_q <= IW'(len_q - 1'b1);
						end
						CMD_NEXT: begin
							if (!cv_q || cur_w + 1'b1 >= len_w) st_q <= ST_RANGE;
							else cur_q <= cur_q + 1'b1;
						end
						CMD_PREV: begin
							if (!cv_q || cur_q == '0) st_q <= ST_RANGE;
							else cur_q <= cur_q - 1'b1;
						end
						CMD_SEEK, CMD_REPL_POS: begin
							if (pos_w < len_w) cur_q <= IW'(pos_q);
							else st_q <= ST_RANGE;
						end
						CMD_DELETE: begin
							if (!cv_q || cur_w >= len_w) st_q <= ST_RANGE;
							else begin
								len_q <= len_q - 1'b1;
								if (len_q == LW'(1)) begin
									cv_q <= 1'b0;
									cur_q <= '0;
								end else if (cur_w >= len_w - 1'b1) begin
									cur_q <= '0;
								end
							end
						end
						CMD_REPL_CUR: if (!cv_q || cur_w >= len_w) st_q <= ST_RANGE;
						CMD_CLEAR: begin
							len_q <= '0;
							cur_q <= '0;
							cv_q <= 1'b0;
						end
						default: st_q <= ST_OK;
					endcase
				end
				S_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_end) begin
						scan_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
					if (cmd_q == CMD_FIND) begin
						if (mc_q == '0) st_q <= ST_NONE;
						else begin
							cur_q <= first_q;
							cv_q <= 1'b1;
						end
					end
					if (cmd_q == CMD_LIST) begin
						if (mc_q == '0) st_q <= ST_NONE;
						else state_q <= S_SCAN2;
					end
					if (cmd_q == CMD_DUMP && len_q != '0) state_q <= S_IDLE;
				end
				S_SCAN2: begin
					scan_q <= scan_q + 1'b1;
					if (scan_end) begin
						scan_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = state_q != S_IDLE;
	assign length = 6'(len_q);
	assign cursor_ok = cv_q;
	assign cursor_pos = 5'(cur_q);

	always_comb begin
		done = 1'b0;
		status = ST_OK;
		item_value = 8'h00;
		item_position = 5'd0;
		match_count = 6'd0;
		last = 1'b0;
		priority case (state_q)
			S_SCAN: begin
				done = cmd_q == CMD_DUMP && in_range;
				item_value = head;
				item_position = 5'(scan_q);
				last = LW'(scan_q) == len_q - 1'b1;
			end
			S_SCAN2: begin
				done = hit;
				item_value = val_q;
				item_position = 5'(scan_q);
				match_count = 6'(mc_q);
				last = run_q + 1'b1 == mc_q;
			end
			S_DONE: begin
				done = 1'b1;
				status = st_q;
				if (cv_q && cur_w < len_w)
					item_value = (cmd_q == CMD_FIND && found_q) ? fb_q : cb_q;
				item_position = cv_q ? 5'(cur_q) : 5'd0;
				match_count = 6'(mc_q);
				last = 1'b1;
			end
			default: done = 1'b0;
		endcase
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result outside a request");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY)) else $error("length beyond capacity");
	a_cur_in: assert property (@(posedge clk) disable iff (!arst_n)
		cv_q |-> cur_w < len_w) else $error("cursor beyond length");
	a_nocur: assert property (@(posedge clk) disable iff (!arst_n)
		!cv_q |-> (cur_q == '0 && len_q == '0)) else $error("stale cursor");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |=> !busy) else $error("busy after final result");
endmodule
`default_nettype wire

FILE: verif/testbench.sv
// testbench for the cursor character list unit
// drives commands against an internal list predictor and checks every result
// depends on ccl_pkg and cursor_char_list_unit
`timescale 1ns / 1ps
`default_nettype none
module testbench import ccl_pkg::*; ();

	localparam int CAP = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] item_value;
		logic [4:0] item_position;
		logic [5:0] match_count;
		logic [5:0] length;
		logic       cursor_ok;
		logic [4:0] cursor_pos;
		logic       last;
	} list_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [4:0] command = '0;
	logic [7:0] value = '0;
	logic [4:0] position = '0;
	logic       busy, done, cursor_ok, last;
	logic [1:0] status;
	logic [7:0] item_value;
	logic [4:0] item_position, cursor_pos;
	logic [5:0] match_count, length;

	logic [7:0] chars [CAP];
	int unsigned         list_len = 0;
	int unsigned         cur_idx = 0;
	bit                  cur_valid = 0;
	list_result_t        pending_results [$];
	int                  mismatches = 0;
	int                  idle_pct = 0;
	int                  quiet_cycles = 0;

	cursor_char_list_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .command(command),
		.value(value), .position(position), .busy(busy), .done(done),
		.status(status), .item_value(item_value),
		.item_position(item_position), .match_count(match_count),
		.length(length), .cursor_ok(cursor_ok), .cursor_pos(cursor_pos),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_result_t make_result(logic [1:0] st, logic [7:0] iv,
			logic [4:0] ip, logic [5:0] mc, logic lst);
		list_result_t r;
		r.status = st;
		r.item_value = iv;
		r.item_position = ip;
		r.match_count = mc;
		r.length = list_len[5:0];
		r.cursor_ok = cur_valid;
		r.cursor_pos = cur_idx[4:0];
		r.last = lst;
		return r;
	endfunction

	function automatic void insert_char(int unsigned p, logic [7:0] v);
		for (int unsigned i = list_len; i > p; i--)
			chars[i] = chars[i-1];
		chars[p] = v;
		list_len++;
		cur_idx = p;
		cur_valid = 1;
	endfunction

	function automatic logic [7:0] flip_case(logic [7:0] c, bit up, bit down);
		if (up && c >= LOWER_A && c <= LOWER_Z)
			return c - CASE_OFS;
		if (down && c >= UPPER_A && c <= UPPER_Z)
			return c + CASE_OFS;
		return c;
	endfunction

	// updates the list copy and queues the results of one request
	function automatic void predict_list(logic [4:0] cmd, logic [7:0] v, logic [4:0] pos);
		logic [1:0] st;
		int unsigned mc, first, n;
		st = ST_OK;
		mc = 0;
		first = 0;
		n = 0;
		if (cmd == CMD_FIND || cmd == CMD_COUNT || cmd == CMD_LIST)
			for (int unsigned i = list_len; i > 0; i--)
				if (chars[i-1] == v) begin
					mc++;
					first = i - 1;
				end
		case (cmd)
			CMD_INS_AFTER: if (list_len >= CAP) st = ST_FULL;
				else insert_char(cur_valid ? cur_idx + 1 : 0, v);
			CMD_INS_FIRST: if (list_len >= CAP) st = ST_FULL;
				else insert_char(0, v);
			CMD_FIRST: if (!cur_valid) st = ST_RANGE; else cur_idx = 0;
			CMD_LAST: if (!cur_valid) st = ST_RANGE; else cur_idx = list_len - 1;
			CMD_NEXT: if (!cur_valid || cur_idx + 1 >= list_len) st = ST_RANGE;
				else cur_idx++;
			CMD_PREV: if (!cur_valid || cur_idx == 0) st = ST_RANGE; else cur_idx--;
			CMD_SEEK: if (pos < list_len) cur_idx = pos; else st = ST_RANGE;
			CMD_REPL_POS: if (pos < list_len) begin
				chars[pos] = v;
				cur_idx = pos;
			end else st = ST_RANGE;
			CMD_DELETE: if (!cur_valid || cur_idx >= list_len) st = ST_RANGE;
			else begin
				for (int unsigned i = cur_idx; i + 1 < list_len; i++)
					chars[i] = chars[i+1];
				list_len--;
				if (list_len == 0) begin
					cur_valid = 0;
					cur_idx = 0;
				end else if (cur_idx >= list_len) cur_idx = 0;
			end
			CMD_REPL_CUR: if (!cur_valid || cur_idx >= list_len) st = ST_RANGE;
				else chars[cur_idx] = v;
			CMD_FIND: if (mc == 0) st = ST_NONE;
			else begin
				cur_idx = first;
				cur_valid = 1;
			end
			CMD_LIST: begin
				for (int unsigned i = 0; i < list_len; i++)
					if (chars[i] == v) begin
						n++;
						pending_results.push_back(make_result(ST_OK, v, i[4:0], mc[5:0],
							n == mc));
					end
				if (n == 0) st = ST_NONE;
				else return;
			end
			CMD_UPPER: for (int unsigned i = 0; i < list_len; i++)
				chars[i] = flip_case(chars[i], 1, 0);
			CMD_LOWER: for (int unsigned i = 0; i < list_len; i++)
				chars[i] = flip_case(chars[i], 0, 1);
			CMD_TOGGLE: for (int unsigned i = 0; i < list_len; i++)
				chars[i] = flip_case(chars[i], 1, 1);
			CMD_CLEAR: begin
				list_len = 0;
				cur_idx = 0;
				cur_valid = 0;
			end
			CMD_DUMP: begin
				if (list_len == 0)
					pending_results.push_back(make_result(ST_OK, 8'd0, 5'd0, 6'd0, 1'b1));
				for (int unsigned i = 0; i < list_len; i++)
					pending_results.push_back(make_result(ST_OK, chars[i], i[4:0], 6'd0,
						i + 1 == list_len));
				return;
			end
			default: ;
		endcase
		pending_results.push_back(make_result(st,
			cur_valid && cur_idx < list_len ? chars[cur_idx] : 8'd0,
			cur_valid ? cur_idx[4:0] : 5'd0, mc[5:0], 1'b1));
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at %0t", $realtime);
			end else begin
				list_result_t exp_r, got_r;
				exp_r = pending_results.pop_front();
				got_r = '{status, item_value, item_position, match_count, length,
					cursor_ok, cursor_pos, last};
				if (got_r !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: expected %p, actual %p", $realtime,
							exp_r, got_r);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// start is held until the edge that takes the request, then dropped
	task automatic send_request(logic [4:0] cmd, logic [7:0] v, logic [4:0] pos);
		while ($urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		value <= v;
		position <= pos;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_list(cmd, v, pos);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(CMD_NEXT, 8'h00, 5'd0);
		send_request(CMD_PREV, 8'hff, 5'd0);
		send_request(CMD_FIRST, 8'h00, 5'd0);
		send_request(CMD_LAST, 8'h00, 5'd0);
		send_request(CMD_DELETE, 8'h00, 5'd0);
		send_request(CMD_REPL_CUR, 8'h41, 5'd0);
		send_request(CMD_DUMP, 8'h00, 5'd0);
		send_request(CMD_LIST, 8'h61, 5'd0);
		send_request(CMD_INS_AFTER, 8'h61, 5'd0);
		send_request(CMD_INS_FIRST, 8'h5a, 5'd31);
		send_request(CMD_INS_AFTER, 8'hff, 5'd0);
		send_request(CMD_INS_AFTER, 8'h7a, 5'd0);
		send_request(CMD_SEEK, 8'h00, 5'd31);
		send_request(CMD_REPL_POS, 8'h40, 5'd2);
		send_request(CMD_TOGGLE, 8'h00, 5'd0);
		send_request(CMD_UPPER, 8'h00, 5'd0);
		send_request(CMD_LOWER, 8'h00, 5'd0);
		send_request(CMD_FIND, 8'h7a, 5'd0);
		send_request(CMD_COUNT, 8'h5b, 5'd0);
		send_request(CMD_LAST, 8'h00, 5'd0);
		send_request(CMD_DELETE, 8'h00, 5'd0);
		send_request(CMD_DUMP, 8'h00, 5'd0);
		send_request(5'd31, 8'h00, 5'd0);
		send_request(CMD_CLEAR, 8'h00, 5'd0);
	endtask

	task automatic test_full_list();
		for (int i = 0; i < CAP + 2; i++)
			send_request(5'($urandom_range(1, 0)), 8'($urandom_range(255, 0)), 5'd0);
		send_request(CMD_LIST, chars[3], 5'd0);
		send_request(CMD_DUMP, 8'h00, 5'd0);
		send_request(CMD_SEEK, 8'h00, 5'd31);
		send_request(CMD_NEXT, 8'h00, 5'd0);
		send_request(CMD_REPL_POS, 8'h80, 5'd31);
	endtask

	task automatic test_random(int count);
		logic [4:0] cmd;
		logic [7:0] v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99, 0) < 5)
				cmd = 5'($urandom_range(31, 18));
			else if (list_len < 4 || $urandom_range(99, 0) < 25)
				cmd = 5'($urandom_range(1, 0));
			else if ($urandom_range(99, 0) < 4)
				cmd = CMD_CLEAR;
			else
				cmd = 5'($urandom_range(CMD_DUMP - 1, 2));
			// small alphabet so searches hit, plus full byte range
			if ($urandom_range(1, 0))
				v = 8'($urandom_range(255, 0));
			else
				v = 8'($urandom_range(3, 0)) + ($urandom_range(1, 0) ? UPPER_A : LOWER_A);
			send_request(cmd, v, 5'($urandom_range(31, 0)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_list();
		send_request(CMD_CLEAR, 8'h00, 5'd0);
		wait_drained();
		idle_pct = 0;
		test_random(80);
		idle_pct = 83;
		test_random(70);
		wait_drained();
		idle_pct = 34;
		test_random(70);
		idle_pct = 0;
		test_random(40);
		wait_drained();
		repeat (2 * CAP + 10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
